/* design/alle_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alle_pkg
// Shared widths, node pool size, request kinds and status codes of the
// array linked list engine.
// ---------------------------------------------------------------------------
package alle_pkg;

	// node pool, the index width follows from the pool size
	localparam int NODES  = 1024;
	localparam int IDX_W  = $clog2(NODES);
	localparam int CNT_W  = IDX_W + 1;
	localparam int DATA_W = 32;

	// request kinds
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BAD_ADDR = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	// full-pool count
	localparam logic [CNT_W-1:0] POOL_FULL = CNT_W'(NODES);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

endpackage

/* design/array_linked_list_engine_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// array_linked_list_engine_top
// Doubly linked list kept in three node memories (value, previous, next)
// with node 0 as head sentinel and a counter handing out fresh nodes.
// ---------------------------------------------------------------------------
// Usage:
//  - input channel in_valid / in_stall carries one request item (kind, addr,
//    value); kind 0 inserts a node after addr, 1 unlinks addr, 2 reads addr
//  - output channel out_valid / out_stall returns exactly one result item
//    per request: status, new_node and the read fields
//  - a small sequencer drives single-port node memories with registered
//    read data; each item is one link read in S_EXEC, then writes in
//    S_APPLY for an insert or delete and in S_LINK for an insert, so the
//    memory ports set the rate; an insert steps through S_EXEC, S_APPLY,
//    S_LINK and S_RESP; a delete or read skips S_LINK, a rejected one S_APPLY
//  - the result sits in an output register; the next item is accepted while
//    it waits, and a finished item waits in the sequencer only while the
//    output register is still full and stalled
//  - in_stall is high while an item is being worked on
//  - reset empties the list: the head has no successor and the next fresh
//    node is 1; node memories need no clearing since a node is always
//    written before it can be read
// ---------------------------------------------------------------------------
module array_linked_list_engine_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         kind,
	input  logic [alle_pkg::IDX_W-1:0]         addr,
	input  logic signed [alle_pkg::DATA_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         status,
	output logic [alle_pkg::IDX_W-1:0]         new_node,
	output logic signed [alle_pkg::DATA_W-1:0] read_value,
	output logic [alle_pkg::IDX_W-1:0]         read_prev,
	output logic [alle_pkg::IDX_W-1:0]         read_next
);
	import alle_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_APPLY,
		S_LINK,
		S_RESP
	} state_t;

	state_t             state_q;
	logic [1:0]         kind_q;
	idx_t               addr_q;
	logic [DATA_W-1:0]  value_q;
	cnt_t               next_free_q;
	idx_t               head_next_q;
	idx_t               succ_q;

	logic [1:0]         res_status_q;
	idx_t               res_new_q;
	logic [DATA_W-1:0]  res_value_q;
	idx_t               res_prev_q;
	idx_t               res_next_q;

	logic               out_valid_q;
	logic [1:0]         out_status_q;
	idx_t               out_new_q;
	logic [DATA_W-1:0]  out_value_q;
	idx_t               out_prev_q;
	idx_t               out_next_q;

	// node memories
	logic [DATA_W-1:0]  value_mem [NODES];
	idx_t               prev_mem  [NODES];
	idx_t               next_mem  [NODES];
	logic [DATA_W-1:0]  value_rd_q;
	idx_t               prev_rd_q;
	idx_t               next_rd_q;

	logic               value_we;
	logic               prev_we;
	logic               next_we;
	idx_t               prev_wa;
	idx_t               next_wa;
	idx_t               prev_wd;
	idx_t               next_wd;
	logic               rd_en;

	idx_t               fresh;
	idx_t               succ;
	logic               addr_alloc;
	logic               out_free;

	assign fresh      = next_free_q[IDX_W-1:0];
	assign succ       = (addr_q == '0) ? head_next_q : next_rd_q;
	assign addr_alloc = {1'b0, addr_q} < next_free_q;
	assign out_free   = !out_valid_q || !out_stall;

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign new_node   = out_new_q;
	assign read_value = out_value_q;
	assign read_prev  = out_prev_q;
	assign read_next  = out_next_q;

	// memory port control
	always_comb begin
		rd_en    = (state_q == S_EXEC);
		value_we = 1'b0;
		prev_we  = 1'b0;
		next_we  = 1'b0;
		prev_wa  = fresh;
		next_wa  = fresh;
		prev_wd  = addr_q;
		next_wd  = succ;
		case (state_q)
			S_APPLY: begin
				if (kind_q == KIND_INSERT) begin
					value_we = 1'b1;
					prev_we  = 1'b1;
					next_we  = 1'b1;
				end else if (kind_q == KIND_DELETE) begin
					// unlink: prev[after] = before, next[before] = after
					prev_we = (next_rd_q != '0);
					prev_wa = next_rd_q;
					prev_wd = prev_rd_q;
					next_we = (prev_rd_q != '0);
					next_wa = prev_rd_q;
					next_wd = next_rd_q;
				end
			end
			S_LINK: begin
				// hook the fresh node between addr and its old successor
				prev_we = (succ_q != '0);
				prev_wa = succ_q;
				prev_wd = fresh;
				next_we = (addr_q != '0);
				next_wa = addr_q;
				next_wd = fresh;
			end
			default: begin
			end
		endcase
	end

	// value memory
	always_ff @(posedge clk) begin
		if (value_we) value_mem[fresh] <= value_q;
		if (rd_en) value_rd_q <= value_mem[addr_q];
	end

	// previous-link memory
	always_ff @(posedge clk) begin
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		if (rd_en) prev_rd_q <= prev_mem[addr_q];
	end

	// next-link memory, head entry lives in head_next_q
	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_wa] <= next_wd;
		if (rd_en) next_rd_q <= next_mem[addr_q];
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			next_free_q  <= cnt_t'(1);
			head_next_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// output register empties when taken, S_RESP refills it itself
			if (out_valid_q && !out_stall && state_q != S_RESP) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind;
						addr_q  <= addr;
						value_q <= value;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					// guards; reads are issued in this cycle
					res_status_q <= ST_OK;
					res_new_q    <= '0;
					res_value_q  <= '0;
					res_prev_q   <= '0;
					res_next_q   <= '0;
					state_q      <= S_RESP;
					case (kind_q)
						KIND_INSERT: begin
							if (next_free_q == POOL_FULL) res_status_q <= ST_FULL;
							else if (!addr_alloc) res_status_q <= ST_BAD_ADDR;
							else state_q <= S_APPLY;
						end
						KIND_DELETE: begin
							if (next_free_q <= cnt_t'(1)) res_status_q <= ST_EMPTY;
							else if (addr_q == '0 || !addr_alloc)
								res_status_q <= ST_BAD_ADDR;
							else state_q <= S_APPLY;
						end
						KIND_READ: begin
							if (!addr_alloc) res_status_q <= ST_BAD_ADDR;
							else state_q <= S_APPLY;
						end
						default: begin
						end
					endcase
				end
				S_APPLY: begin
					state_q <= S_RESP;
					case (kind_q)
						KIND_INSERT: begin
							succ_q  <= succ;
							state_q <= S_LINK;
						end
						KIND_DELETE: begin
							if (prev_rd_q == '0) head_next_q <= next_rd_q;
						end
						KIND_READ: begin
							if (addr_q == '0) begin
								res_next_q <= head_next_q;
							end else begin
								res_value_q <= value_rd_q;
								res_prev_q  <= prev_rd_q;
								res_next_q  <= next_rd_q;
							end
						end
						default: begin
						end
					endcase
				end
				S_LINK: begin
					if (addr_q == '0) head_next_q <= fresh;
					res_new_q   <= fresh;
					next_free_q <= next_free_q + cnt_t'(1);
					state_q     <= S_RESP;
				end
				S_RESP: begin
					// hand the result to the output register once it is free
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_new_q    <= res_new_q;
						out_value_q  <= res_value_q;
						out_prev_q   <= res_prev_q;
						out_next_q   <= res_next_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
